// ----- sv/sstq_pkg.sv -----
package sstq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int TIME_W  = 63;
  localparam int TICKS_W = 64;
  localparam int ID_W    = 8;
  localparam int BATCH_W = 6;
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 2;

  // Wake time that means "nothing queued"
  localparam logic [TIME_W-1:0] WAKE_NONE = '1;

  // Reset value of the batch register
  localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(8);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE  = 2'd2;

  // Status codes
  localparam logic [CODE_W-1:0] ST_OK      = 2'd0;
  localparam logic [CODE_W-1:0] ST_FULL    = 2'd1;
  localparam logic [CODE_W-1:0] ST_IGNORED = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WOKEN  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;       // take the input beat and run its first step
    logic pop_emit;     // release the queue head as a woken beat
    logic head_upd;     // record the head wake time as earliest
    logic set_more;     // batch limit reached
    logic emit_status;  // send the closing status beat
  } sstq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;     // output register can take a beat this cycle
    logic head_due;     // queue head is due at the current tick
    logic batch_hit;    // this pop reaches the batch limit
    logic batch_zero;   // batch register is zero
  } sstq_stat_t;

endpackage

// ----- sv/sstq_queue.sv -----
module sstq_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ins,
  input  logic [sstq_pkg::TIME_W-1:0] ins_time,
  input  logic [sstq_pkg::ID_W-1:0]   ins_id,
  input  logic                        pop,
  output logic [sstq_pkg::TIME_W-1:0] head_time,
  output logic [sstq_pkg::ID_W-1:0]   head_id,
  output logic                        full,
  output logic                        empty
);
  import sstq_pkg::*;

  logic [TIME_W-1:0] time_r [QUEUE_DEPTH];
  logic [ID_W-1:0]   id_r   [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [QUEUE_DEPTH-1:0] gtx;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_time = time_r[0];
  assign head_id   = id_r[0];

  // Mark cells at or past the insert point: free slots and later wake times
  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign gtx[i] = (CNT_W'(i) >= count_r) || (time_r[i] > ins_time);

      if (i == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (ins && gtx[i]) begin
            time_r[i] <= ins_time;
            id_r[i]   <= ins_id;
          end else if (pop && (QUEUE_DEPTH > 1)) begin
            time_r[i] <= time_r[(QUEUE_DEPTH > 1) ? 1 : 0];
            id_r[i]   <= id_r[(QUEUE_DEPTH > 1) ? 1 : 0];
          end
        end
      end else if (i == QUEUE_DEPTH - 1) begin : g_tail
        always_ff @(posedge clk) begin
          if (ins && gtx[i]) begin
            time_r[i] <= gtx[i-1] ? time_r[i-1] : ins_time;
            id_r[i]   <= gtx[i-1] ? id_r[i-1]   : ins_id;
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (ins && gtx[i]) begin
            time_r[i] <= gtx[i-1] ? time_r[i-1] : ins_time;
            id_r[i]   <= gtx[i-1] ? id_r[i-1]   : ins_id;
          end else if (pop) begin
            time_r[i] <= time_r[i+1];
            id_r[i]   <= id_r[i+1];
          end
        end
      end
    end
  endgenerate

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    ins |-> !full) else $error("insert into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_ins_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ins && pop)) else $error("insert and pop in one cycle");
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins |=> count_r == $past(count_r) + CNT_W'(1)) else $error("count not advanced");
`endif

endmodule

// ----- sv/sstq_ctrl.sv -----
module sstq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [sstq_pkg::CMD_W-1:0]    in_command,
  output logic                          in_stall,
  input  sstq_pkg::sstq_stat_t          stat,
  output sstq_pkg::sstq_cmd_t           cmd
);
  import sstq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WAKE   = 2'd1;
  localparam logic [1:0] S_STATUS = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequence one command: accept, optional wakeup loop, closing status
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_WAKE && !stat.batch_zero) begin
            state_nxt = S_WAKE;
          end else begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_WAKE: begin
        if (stat.out_free) begin
          if (stat.head_due) begin
            cmd.pop_emit = 1'b1;
            if (stat.batch_hit) begin
              cmd.set_more = 1'b1;
              state_nxt    = S_STATUS;
            end
          end else begin
            cmd.head_upd = 1'b1;
            state_nxt    = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/sstq_dp.sv -----
module sstq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sstq_pkg::sstq_cmd_t                 cmd,
  output sstq_pkg::sstq_stat_t                stat,
  input  logic                                cfg_wr_en,
  input  logic [sstq_pkg::BATCH_W-1:0]        cfg_wr_data,
  input  logic [sstq_pkg::CMD_W-1:0]          in_command,
  input  logic [sstq_pkg::ID_W-1:0]           in_thread_id,
  input  logic signed [sstq_pkg::TICKS_W-1:0] in_sleep_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [sstq_pkg::ID_W-1:0]           out_woken_id,
  output logic [sstq_pkg::CODE_W-1:0]         out_status_code,
  output logic                                out_more_pending,
  output logic [sstq_pkg::TIME_W-1:0]         out_next_wake_time,
  output logic                                out_last
);
  import sstq_pkg::*;

  logic [TIME_W-1:0]  tick_r,     tick_nxt;
  logic [TIME_W-1:0]  earliest_r, earliest_nxt;
  logic [BATCH_W-1:0] batch_r,    batch_nxt;
  logic [BATCH_W-1:0] woken_r,    woken_nxt;
  logic [TIME_W-1:0]  wake_r,     wake_nxt;
  logic [ID_W-1:0]    id_r,       id_nxt;
  logic [CODE_W-1:0]  code_r,     code_nxt;
  logic               ins_pend_r, ins_pend_nxt;
  logic               wake_act_r, wake_act_nxt;
  logic               more_r,     more_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r,  out_kind_nxt;
  logic [ID_W-1:0]    out_id_r,    out_id_nxt;
  logic [CODE_W-1:0]  out_code_r,  out_code_nxt;
  logic               out_more_r,  out_more_nxt;
  logic [TIME_W-1:0]  out_nwt_r,   out_nwt_nxt;
  logic               out_last_r,  out_last_nxt;

  logic [TIME_W:0]    wake_sum;
  logic [TIME_W-1:0]  wake_sat;
  logic               ticks_bad;
  logic [TIME_W-1:0]  status_nwt;

  logic               q_ins;
  logic [TIME_W-1:0]  q_head_time;
  logic [ID_W-1:0]    q_head_id;
  logic               q_full;
  logic               q_empty;

  sstq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ins       (q_ins),
    .ins_time  (wake_r),
    .ins_id    (id_r),
    .pop       (cmd.pop_emit),
    .head_time (q_head_time),
    .head_id   (q_head_id),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Insert a pending sleep request as the status beat goes out
  assign q_ins = cmd.emit_status && ins_pend_r;

  // Saturating wake time; both operands stay below 2^63
  assign wake_sum  = {1'b0, tick_r} + {1'b0, in_sleep_ticks[TIME_W-1:0]};
  assign wake_sat  = wake_sum[TIME_W] ? WAKE_NONE : wake_sum[TIME_W-1:0];
  assign ticks_bad = in_sleep_ticks[TICKS_W-1] || (in_sleep_ticks == '0);

  // Earliest wake time reported and kept by the status beat
  always_comb begin
    if (ins_pend_r) begin
      status_nwt = (wake_r < earliest_r) ? wake_r : earliest_r;
    end else if (wake_act_r && q_empty) begin
      status_nwt = WAKE_NONE;
    end else begin
      status_nwt = earliest_r;
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.head_due   = !q_empty && (q_head_time <= tick_r);
  assign stat.batch_hit  = ((woken_r + BATCH_W'(1)) == batch_r);
  assign stat.batch_zero = (batch_r == '0);

  // Next state of the datapath
  always_comb begin
    tick_nxt      = tick_r;
    earliest_nxt  = earliest_r;
    batch_nxt     = batch_r;
    woken_nxt     = woken_r;
    wake_nxt      = wake_r;
    id_nxt        = id_r;
    code_nxt      = code_r;
    ins_pend_nxt  = ins_pend_r;
    wake_act_nxt  = wake_act_r;
    more_nxt      = more_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_code_nxt  = out_code_r;
    out_more_nxt  = out_more_r;
    out_nwt_nxt   = out_nwt_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      batch_nxt = cfg_wr_data;
    end

    // Decode the accepted beat
    if (cmd.accept) begin
      woken_nxt    = '0;
      more_nxt     = 1'b0;
      ins_pend_nxt = 1'b0;
      wake_act_nxt = 1'b0;
      wake_nxt     = wake_sat;
      id_nxt       = in_thread_id;
      code_nxt     = ST_OK;
      case (in_command)
        CMD_TICK: begin
          if (tick_r != WAKE_NONE) begin
            tick_nxt = tick_r + TIME_W'(1);
          end
        end
        CMD_SLEEP: begin
          if (ticks_bad) begin
            code_nxt = ST_IGNORED;
          end else if (q_full) begin
            code_nxt = ST_FULL;
          end else begin
            ins_pend_nxt = 1'b1;
          end
        end
        CMD_WAKE: begin
          if (batch_r == '0) begin
            code_nxt = ST_IGNORED;
          end else begin
            wake_act_nxt = 1'b1;
          end
        end
        default: begin
          code_nxt = ST_IGNORED;
        end
      endcase
    end

    // Release the head as a woken beat
    if (cmd.pop_emit) begin
      woken_nxt     = woken_r + BATCH_W'(1);
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_WOKEN;
      out_id_nxt    = q_head_id;
      out_code_nxt  = ST_OK;
      out_more_nxt  = 1'b0;
      out_nwt_nxt   = '0;
      out_last_nxt  = 1'b0;
    end

    if (cmd.set_more) begin
      more_nxt = 1'b1;
    end

    // Head not due: it now holds the earliest wake time
    if (cmd.head_upd && !q_empty) begin
      earliest_nxt = q_head_time;
    end

    // Close the command with a status beat
    if (cmd.emit_status) begin
      earliest_nxt  = status_nwt;
      ins_pend_nxt  = 1'b0;
      wake_act_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_STATUS;
      out_id_nxt    = '0;
      out_code_nxt  = code_r;
      out_more_nxt  = more_r && !q_empty;
      out_nwt_nxt   = status_nwt;
      out_last_nxt  = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      earliest_r  <= WAKE_NONE;
      batch_r     <= BATCH_RESET;
      ins_pend_r  <= 1'b0;
      wake_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      earliest_r  <= earliest_nxt;
      batch_r     <= batch_nxt;
      ins_pend_r  <= ins_pend_nxt;
      wake_act_r  <= wake_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    woken_r    <= woken_nxt;
    wake_r     <= wake_nxt;
    id_r       <= id_nxt;
    code_r     <= code_nxt;
    more_r     <= more_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_code_r <= out_code_nxt;
    out_more_r <= out_more_nxt;
    out_nwt_r  <= out_nwt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_woken_id       = out_id_r;
  assign out_status_code    = out_code_r;
  assign out_more_pending   = out_more_r;
  assign out_next_wake_time = out_nwt_r;
  assign out_last           = out_last_r;

endmodule

// ----- sv/sorted_sleep_timer_queue.sv -----
// Channel  Direction  Handshake         Beat
// in_      input      in_valid/stall    command, thread id, sleep ticks
// out_     output     out_valid/stall   woken thread id or closing status
// cfg_     input      cfg_wr_en         max wakeup batch (6 bits)
//
// Tick, sleep, unknown and zero-batch wakeup commands: accept, then the status beat.
// A wakeup is accepted, pops one due head per woken thread, records the head wake
//   time unless it stops at the batch limit, then sends the status beat. The shift
//   queue releases one head per cycle while the output is free.
// Synchronous active-low reset clears tick count and queue fill, sets earliest wake
//   to WAKE_NONE and loads the batch size with 8; queue cells need no clearing pass.
// A stalled output beat holds the sequencer until the beat is taken.
module sorted_sleep_timer_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sstq_pkg::CMD_W-1:0]          in_command,
  input  logic [sstq_pkg::ID_W-1:0]           in_thread_id,
  input  logic signed [sstq_pkg::TICKS_W-1:0] in_sleep_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [sstq_pkg::ID_W-1:0]           out_woken_id,
  output logic [sstq_pkg::CODE_W-1:0]         out_status_code,
  output logic                                out_more_pending,
  output logic [sstq_pkg::TIME_W-1:0]         out_next_wake_time,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [sstq_pkg::BATCH_W-1:0]        cfg_wr_data
);
  import sstq_pkg::*;

  sstq_cmd_t  cmd;
  sstq_stat_t stat;

  sstq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  sstq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_command         (in_command),
    .in_thread_id       (in_thread_id),
    .in_sleep_ticks     (in_sleep_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_woken_id       (out_woken_id),
    .out_status_code    (out_status_code),
    .out_more_pending   (out_more_pending),
    .out_next_wake_time (out_next_wake_time),
    .out_last           (out_last)
  );

endmodule

// ----- sim/tb_sorted_sleep_timer_queue.sv -----
`timescale 1ns / 100ps

module tb_sorted_sleep_timer_queue;
  import sstq_pkg::*;

  localparam logic [63:0] NONE64    = {1'b0, WAKE_NONE};
  localparam logic [63:0] TICKS_MIN = 64'h8000_0000_0000_0000;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic [CODE_W-1:0] code;
    logic              more;
    logic [TIME_W-1:0] nwt;
    logic              last;
  } result_beat_t;

  // Clock and block ports; the driven inputs are known from time zero
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command = '0;
  logic [ID_W-1:0]           in_thread_id = '0;
  logic signed [TICKS_W-1:0] in_sleep_ticks = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_kind;
  logic [ID_W-1:0]           out_woken_id;
  logic [CODE_W-1:0]         out_status_code;
  logic                      out_more_pending;
  logic [TIME_W-1:0]         out_next_wake_time;
  logic                      out_last;
  logic                      cfg_wr_en = 1'b0;
  logic [BATCH_W-1:0]        cfg_wr_data = '0;

  // Predicted timer state
  logic [63:0]        sim_ticks;
  logic [63:0]        sim_when [QUEUE_DEPTH];
  logic [ID_W-1:0]    sim_who  [QUEUE_DEPTH];
  int                 sim_fill;
  logic [63:0]        sim_earliest;
  logic [BATCH_W-1:0] sim_batch;

  result_beat_t pending_beats [$];

  int  n_errors = 0;
  int  n_items = 0;
  int  n_beats = 0;
  int  n_woken = 0;
  int  n_full = 0;
  int  n_more = 0;
  int  burst_left = 0;
  bit  valid_hi = 1'b0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  stall_mode = 0;

  sorted_sleep_timer_queue DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_thread_id       (in_thread_id),
    .in_sleep_ticks     (in_sleep_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_woken_id       (out_woken_id),
    .out_status_code    (out_status_code),
    .out_more_pending   (out_more_pending),
    .out_next_wake_time (out_next_wake_time),
    .out_last           (out_last),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("MISMATCH at beat %0d: %s got %0h want %0h", n_beats, what, got, want);
  endtask

  // Work out the beats one command causes and advance the timer state
  task automatic predict_beats(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                               input logic [63:0] ticks);
    result_beat_t st;
    result_beat_t wk;
    logic [63:0]  wake;
    int           pos;
    int           woken;
    logic         more;
    bit           done;
    st = '0;
    st.last = 1'b1;
    case (cmd)
      CMD_TICK: begin
        if (sim_ticks < NONE64) sim_ticks++;
      end
      CMD_SLEEP: begin
        if (ticks[63] || ticks == 64'd0) begin
          st.code = ST_IGNORED;
        end else if (sim_fill >= QUEUE_DEPTH) begin
          st.code = ST_FULL;
          n_full++;
        end else begin
          wake = sim_ticks + ticks;
          if (wake > NONE64) wake = NONE64;
          // find the slot after every entry due no later, then shift up
          pos = sim_fill;
          while (pos > 0 && sim_when[pos-1] > wake) pos--;
          for (int i = sim_fill; i > pos; i--) begin
            sim_when[i] = sim_when[i-1];
            sim_who[i]  = sim_who[i-1];
          end
          sim_when[pos] = wake;
          sim_who[pos]  = id;
          sim_fill++;
          if (wake < sim_earliest) sim_earliest = wake;
        end
      end
      CMD_WAKE: begin
        if (sim_batch == '0) begin
          st.code = ST_IGNORED;
        end else begin
          woken = 0;
          more  = 1'b0;
          done  = 1'b0;
          // release due heads until the batch is used up or no head is due
          while (sim_fill > 0 && !done) begin
            if (sim_when[0] <= sim_ticks) begin
              wk = '0;
              wk.kind = KIND_WOKEN;
              wk.id   = sim_who[0];
              pending_beats.push_back(wk);
              n_woken++;
              for (int i = 1; i < sim_fill; i++) begin
                sim_when[i-1] = sim_when[i];
                sim_who[i-1]  = sim_who[i];
              end
              sim_fill--;
              woken++;
              if (woken == int'(sim_batch)) begin
                more = 1'b1;
                done = 1'b1;
              end
            end else begin
              sim_earliest = sim_when[0];
              done = 1'b1;
            end
          end
          if (sim_fill == 0) begin
            more = 1'b0;
            sim_earliest = NONE64;
          end
          st.more = more;
          if (more) n_more++;
        end
      end
      default: begin
        st.code = ST_IGNORED;
      end
    endcase
    st.nwt = sim_earliest[TIME_W-1:0];
    pending_beats.push_back(st);
  endtask

  // Send one beat, then keep the burst going or open a gap
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [63:0] ticks);
    int gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_thread_id   <= id;
    in_sleep_ticks <= ticks;
    valid_hi = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_beats(cmd, id, ticks);
    n_items++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 40);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 15) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_hi = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every expected beat has come back
  task automatic drain_results();
    if (valid_hi) begin
      in_valid <= 1'b0;
      valid_hi = 1'b0;
      @(posedge clk);
    end
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_batch(input logic [BATCH_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sim_batch = value;
  endtask

  function automatic logic [63:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'($urandom_range(1, 16));
    if (r < 85) return 64'($urandom_range(17, 60));
    if (r < 88) return {1'b0, 31'($urandom), 32'($urandom)};
    if (r < 92) return {32'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      0:       return 64'd0;
      1:       return -64'sd1;
      2:       return TICKS_MIN;
      default: return 64'(-$urandom_range(2, 1000));
    endcase
  endfunction

  // Mixed traffic: mostly sleeps and ticks so that entries come due
  task automatic run_mix(input int n);
    int r;
    int k;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_item(CMD_SLEEP, ID_W'($urandom), pick_ticks());
        k++;
      end else if (r < 68) begin
        send_item(CMD_TICK, ID_W'($urandom), {32'($urandom), 32'($urandom)});
        k++;
      end else if (r < 88) begin
        send_item(CMD_WAKE, ID_W'($urandom), {32'($urandom), 32'($urandom)});
        k++;
      end else if (r < 92) begin
        send_item(CMD_UNKNOWN, ID_W'($urandom), {32'($urandom), 32'($urandom)});
        k++;
      end else begin
        repeat ($urandom_range(3, 8)) begin
          send_item(CMD_TICK, ID_W'($urandom), 64'($urandom));
          k++;
        end
        send_item(CMD_WAKE, ID_W'($urandom), 64'($urandom));
        k++;
      end
    end
  endtask

  task automatic test_directed();
    send_item(CMD_WAKE,    8'h00, 64'd0);
    send_item(CMD_TICK,    8'hFF, '1);
    send_item(CMD_SLEEP,   8'h01, 64'd0);
    send_item(CMD_SLEEP,   8'h02, -64'sd1);
    send_item(CMD_SLEEP,   8'h03, TICKS_MIN);
    send_item(CMD_UNKNOWN, 8'hFF, '1);
    send_item(CMD_SLEEP,   8'h00, 64'd1);
    // saturating wake time
    send_item(CMD_SLEEP,   8'hFF, NONE64);
    // equal wake times keep arrival order
    send_item(CMD_SLEEP,   8'hAA, 64'd3);
    send_item(CMD_SLEEP,   8'h55, 64'd3);
    send_item(CMD_SLEEP,   8'h0F, 64'd2);
    // head not yet due
    send_item(CMD_WAKE,    8'h00, 64'd0);
    send_item(CMD_TICK,    8'h00, 64'd0);
    send_item(CMD_WAKE,    8'h00, 64'd0);
    send_item(CMD_TICK,    8'h00, 64'd0);
    send_item(CMD_TICK,    8'h00, 64'd0);
    send_item(CMD_WAKE,    8'h00, 64'd0);
    send_item(CMD_SLEEP,   8'h80, 64'h4000_0000_0000_0000);
    send_item(CMD_TICK,    8'h00, 64'd0);
    send_item(CMD_WAKE,    8'hFF, 64'd0);
  endtask

  task automatic test_zero_batch();
    set_batch('0);
    send_item(CMD_SLEEP, 8'h11, 64'd1);
    send_item(CMD_TICK,  8'h00, 64'd0);
    send_item(CMD_TICK,  8'h00, 64'd0);
    send_item(CMD_WAKE,  8'h00, 64'd0);
    run_mix(36);
  endtask

  task automatic test_batch_extremes();
    set_batch(BATCH_W'(1));
    run_mix(80);
    set_batch('1);
    run_mix(80);
  endtask

  task automatic test_queue_full();
    set_batch(BATCH_W'(2));
    while (sim_fill < QUEUE_DEPTH)
      send_item(CMD_SLEEP, ID_W'($urandom), 64'($urandom_range(1, 8)));
    send_item(CMD_SLEEP, ID_W'($urandom), 64'd5);
    send_item(CMD_SLEEP, ID_W'($urandom), 64'd0);
    send_item(CMD_SLEEP, ID_W'($urandom), NONE64);
    // drain slowly so the batch limit leaves entries behind
    repeat (20) begin
      send_item(CMD_TICK, ID_W'($urandom), 64'($urandom));
      send_item(CMD_WAKE, ID_W'($urandom), 64'($urandom));
    end
    run_mix(30);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      set_batch(BATCH_W'($urandom_range(1, 63)));
      run_mix(45);
    end
    set_batch(BATCH_RESET);
    run_mix(20);
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin : check_beats
    result_beat_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_beats++;
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", 64'(out_kind), 64'd0);
      end else begin
        want = pending_beats.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", 64'(out_kind), 64'(want.kind));
        if (out_woken_id !== want.id)
          report_mismatch("woken_id", 64'(out_woken_id), 64'(want.id));
        if (out_status_code !== want.code)
          report_mismatch("status_code", 64'(out_status_code), 64'(want.code));
        if (out_more_pending !== want.more)
          report_mismatch("more_pending", 64'(out_more_pending), 64'(want.more));
        if (out_next_wake_time !== want.nwt)
          report_mismatch("next_wake_time", 64'(out_next_wake_time), 64'(want.nwt));
        if (out_last !== want.last)
          report_mismatch("last", 64'(out_last), 64'(want.last));
      end
    end
  end

  // Receiver stall pattern: free runs, light and heavy stalls, solid holds
  always @(posedge clk) begin
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= 1'b1;
    endcase
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    sim_ticks    = '0;
    sim_fill     = 0;
    sim_earliest = NONE64;
    sim_batch    = BATCH_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_batch();
    test_batch_extremes();
    test_queue_full();
    test_random_settings();

    // Let the last beats out, then give the block time to misbehave
    drain_results();
    repeat (20) @(posedge clk);
    if (pending_beats.size() != 0)
      report_mismatch("beats never delivered", 64'(pending_beats.size()), 64'd0);

    $display("Sent %0d commands and checked %0d result beats (%0d woken threads).",
             n_items, n_beats, n_woken);
    $display("Saw %0d full-queue drops, %0d batch-limited wakeups, %0d mismatches.",
             n_full, n_more, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
